// ===== src/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a condition implies a property on the same edge.
`define ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
// Check that a condition implies a property on the next edge.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`endif

// ===== src/wse_pkg.sv =====
// Shared types and constants of the windowed SNR estimator.
package wse_pkg;
    localparam int SampleWidth = 16;
    localparam int SnrBits = 48;
    localparam logic OP_ADD = 1'b0;
    localparam logic OP_FLUSH = 1'b1;
    localparam logic [0:0] REG_LENGTH = 1'b0;
    localparam logic [0:0] REG_INFINITE = 1'b1;

    // Window totals handed from the accumulator to the SNR divider.
    typedef struct packed {
        logic [20:0] n;
        logic [36:0] mag;
        logic [63:0] s2;
        logic        bad;
    } wse_job_t;
endpackage

// ===== src/wse_front.sv =====
// Front end: accumulates sums per window and closes windows into jobs.
module wse_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [36:0]      cfg_len,
    input  logic             cfg_inf_we,
    input  logic             cfg_inf,
    input  logic             in_valid,
    input  logic             in_op,
    input  logic [15:0]      in_sample,
    output logic             in_ready,
    output logic             job_valid,
    output wse_pkg::wse_job_t job,
    input  logic             job_ready
);
    import wse_pkg::*;

    localparam logic [20:0] CountCap = 21'd1 << 20;

    logic [36:0] len_reg;
    logic        inf_reg;
    logic [20:0] count_reg;
    logic signed [36:0] sum_reg;
    logic [63:0] sq_reg;
    logic        ovf_reg;
    logic [63:0] endp_reg;
    logic [20:0] size_reg;
    logic        jv_reg;
    wse_job_t    job_reg;

    logic [36:0] eff_len;
    logic [36:0] cfg_eff;
    logic [47:0] ceil_cur, ceil_nxt, diff, ceil_init;
    logic [63:0] endp_nxt;
    logic [20:0] size_nxt, size_init;
    logic        take, add, close;
    logic signed [15:0] xs;
    logic [15:0] xm;
    logic [31:0] sq;
    logic [64:0] sq_sum;
    logic [20:0] cnt_a;
    logic signed [36:0] sum_a;
    logic [63:0] sq_a;
    logic        ovf_a;
    logic [36:0] mag_a;

    function automatic logic [47:0] ceil_of(input logic [63:0] p);
        logic [47:0] c;
        c = p[63:16] + {47'd0, |p[15:0]};
        return c;
    endfunction

    always_comb
    begin
        eff_len = len_reg;
        if (len_reg < 37'd65536) eff_len = 37'd65536;
        if (len_reg > (37'd1 << 36)) eff_len = 37'd1 << 36;
        ceil_cur = ceil_of(endp_reg);
        endp_nxt = endp_reg + {27'd0, eff_len};
        ceil_nxt = ceil_of(endp_nxt);
        diff = ceil_nxt - ceil_cur;
        size_nxt = (diff > 48'h1FFFFF) ? 21'h1FFFFF : diff[20:0];
        if (diff == 48'd0) size_nxt = 21'd1;
        in_ready = !jv_reg || job_ready;
        take = in_valid && in_ready;
        add = take && (in_op == OP_ADD) && (count_reg < CountCap);
        xs = in_sample;
        xm = xs[15] ? 16'(-xs) : xs;
        sq = xm * xm;
        sq_sum = {1'b0, sq_reg} + {33'd0, sq};
        cnt_a = add ? count_reg + 21'd1 : count_reg;
        sum_a = add ? sum_reg + 37'(xs) : sum_reg;
        sq_a = add ? (sq_sum[64] ? '1 : sq_sum[63:0]) : sq_reg;
        ovf_a = ovf_reg || (take && (in_op == OP_ADD) && !(count_reg < CountCap));
        close = take && ((in_op == OP_FLUSH) ? (count_reg != 21'd0)
                                             : (!inf_reg && cnt_a >= size_reg));
        mag_a = sum_a[36] ? 37'(-sum_a) : sum_a;
        // First window after a length write, from the clamped new length.
        cfg_eff = cfg_len;
        if (cfg_len < 37'd65536) cfg_eff = 37'd65536;
        if (cfg_len > (37'd1 << 36)) cfg_eff = 37'd1 << 36;
        ceil_init = ceil_of({27'd0, cfg_eff});
        size_init = (ceil_init > 48'h1FFFFF) ? 21'h1FFFFF : ceil_init[20:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= 37'd67108864;
            inf_reg <= 1'b0;
            count_reg <= '0;
            sum_reg <= '0;
            sq_reg <= '0;
            ovf_reg <= 1'b0;
            endp_reg <= 64'd67108864;
            size_reg <= 21'd1024;
            jv_reg <= 1'b0;
        end
        else
        begin
            if (job_ready) jv_reg <= 1'b0;
            if (cfg_inf_we) inf_reg <= cfg_inf;
            if (cfg_we)
            begin
                len_reg <= cfg_len;
                count_reg <= '0;
                sum_reg <= '0;
                sq_reg <= '0;
                ovf_reg <= 1'b0;
                endp_reg <= {27'd0, cfg_eff};
                size_reg <= size_init;
            end
            else if (take)
            begin
                if (close)
                begin
                    jv_reg <= 1'b1;
                    job_reg <= '{n: cnt_a, mag: mag_a, s2: sq_a, bad: ovf_a};
                    count_reg <= '0;
                    sum_reg <= '0;
                    sq_reg <= '0;
                    ovf_reg <= 1'b0;
                    endp_reg <= endp_nxt;
                    size_reg <= size_nxt;
                end
                else
                begin
                    count_reg <= cnt_a;
                    sum_reg <= sum_a;
                    sq_reg <= sq_a;
                    ovf_reg <= ovf_a;
                end
            end
        end
    end

    assign job_valid = jv_reg;
    assign job = job_reg;
endmodule

// ===== src/wse_back.sv =====
// Back end: shift-add multiplies of the SNR terms, then a one-bit-per-cycle divide.
module wse_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    input  wse_pkg::wse_job_t job,
    output logic             job_ready,
    output logic             res_valid,
    output logic [47:0]      res_snr,
    output logic             res_invalid,
    input  logic             res_pop
);
    import wse_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SQ, S_PREP, S_NMUL, S_DIV, S_OUT} state_t;

    state_t       state_reg;
    wse_job_t     j_reg;
    logic [73:0]  mca_reg;
    logic [36:0]  mpa_reg;
    logic [73:0]  s1sq_reg;
    logic [84:0]  mcb_reg;
    logic [20:0]  mpb_reg;
    logic [84:0]  ns2_reg;
    logic [94:0]  mcn_reg;
    logic [20:0]  mpn_reg;
    logic [94:0]  num_reg;
    logic [105:0] mcd_reg;
    logic [20:0]  mpd_reg;
    logic [105:0] den_reg;
    logic [105:0] rem_reg;
    logic [47:0]  q_reg;
    logic         sat_reg;
    logic         zd_reg;
    logic [6:0]   bit_reg;
    logic [47:0]  snr_reg;
    logic         inv_reg;
    logic         full_reg;

    logic [106:0] rem_sh;
    logic [106:0] rem_sub;
    logic [84:0]  d;
    logic         zd;
    logic         out_load;

    always_comb
    begin
        // Dividend is num * 2^16; its bits enter MSB first.
        rem_sh = {rem_reg, num_reg[94]};
        rem_sub = rem_sh - {1'b0, den_reg};
        d = ns2_reg - {11'd0, s1sq_reg};
        zd = (j_reg.n < 21'd2) || (ns2_reg <= {11'd0, s1sq_reg});
        out_load = (state_reg == S_OUT) && (!full_reg || res_pop);
    end

    assign job_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            full_reg <= 1'b0;
        end
        else
        begin
            if (out_load) full_reg <= 1'b1;
            else if (res_pop) full_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (job_valid)
                    begin
                        j_reg <= job;
                        mca_reg <= {37'd0, job.mag};
                        mpa_reg <= job.mag;
                        mcb_reg <= {21'd0, job.s2};
                        mpb_reg <= job.n;
                        s1sq_reg <= '0;
                        ns2_reg <= '0;
                        bit_reg <= 7'd36;
                        state_reg <= S_SQ;
                    end
                S_SQ:
                begin
                    // S1^2 and n*S2, one multiplier bit per cycle.
                    if (mpa_reg[0]) s1sq_reg <= s1sq_reg + mca_reg;
                    if (mpb_reg[0]) ns2_reg <= ns2_reg + mcb_reg;
                    mca_reg <= {mca_reg[72:0], 1'b0};
                    mpa_reg <= {1'b0, mpa_reg[36:1]};
                    mcb_reg <= {mcb_reg[83:0], 1'b0};
                    mpb_reg <= {1'b0, mpb_reg[20:1]};
                    if (bit_reg == 7'd0) state_reg <= S_PREP;
                    else bit_reg <= bit_reg - 7'd1;
                end
                S_PREP:
                begin
                    zd_reg <= zd;
                    mcn_reg <= {21'd0, s1sq_reg};
                    mpn_reg <= j_reg.n;
                    num_reg <= '0;
                    mcd_reg <= {21'd0, d};
                    mpd_reg <= j_reg.n - 21'd1;
                    den_reg <= '0;
                    rem_reg <= '0;
                    q_reg <= '0;
                    sat_reg <= 1'b0;
                    bit_reg <= 7'd20;
                    state_reg <= zd ? S_OUT : S_NMUL;
                end
                S_NMUL:
                begin
                    // n*S1^2 and (n-1)*(n*S2-S1^2), one bit of n per cycle.
                    if (mpn_reg[0]) num_reg <= num_reg + mcn_reg;
                    if (mpd_reg[0]) den_reg <= den_reg + mcd_reg;
                    mcn_reg <= {mcn_reg[93:0], 1'b0};
                    mpn_reg <= {1'b0, mpn_reg[20:1]};
                    mcd_reg <= {mcd_reg[104:0], 1'b0};
                    mpd_reg <= {1'b0, mpd_reg[20:1]};
                    if (bit_reg == 7'd0)
                    begin
                        bit_reg <= 7'd110;
                        state_reg <= S_DIV;
                    end
                    else bit_reg <= bit_reg - 7'd1;
                end
                S_DIV:
                begin
                    if (rem_sh >= {1'b0, den_reg})
                    begin
                        rem_reg <= rem_sub[105:0];
                        if (bit_reg >= 7'd48) sat_reg <= 1'b1;
                        else q_reg[bit_reg[5:0]] <= 1'b1;
                    end
                    else rem_reg <= rem_sh[105:0];
                    num_reg <= {num_reg[93:0], 1'b0};
                    if (bit_reg == 7'd0) state_reg <= S_OUT;
                    else bit_reg <= bit_reg - 7'd1;
                end
                S_OUT:
                    if (out_load)
                    begin
                        snr_reg <= (zd_reg || sat_reg) ? '1 : q_reg;
                        inv_reg <= zd_reg || j_reg.bad;
                        state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign res_valid = full_reg;
    assign res_snr = snr_reg;
    assign res_invalid = inv_reg;
endmodule

// ===== src/windowed_snr_estimator.sv =====
// Top level of the windowed SNR estimator.
// channel | direction | handshake           | payload
// input   | in        | push / full         | op, sample
// result  | out       | empty / pop         | snr, invalid
// config  | in        | cfg_we              | cfg_index, cfg_data
// A sample is taken each cycle while full is low; full rises only while a
// closed window waits for the divider. The back end runs each window as:
// accept, 37 shift-add steps, setup, 21 shift-add steps, 111 one-bit
// restoring steps, output; a zero denominator skips from setup to output.
// Reset clears all sums and loads L = 1024.0; no clearing pass is needed.
// A stalled result holds on snr/invalid until pop.
module windowed_snr_estimator (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic                             op,
    input  logic [wse_pkg::SampleWidth-1:0]  sample,
    output logic                             empty,
    input  logic                             pop,
    output logic [wse_pkg::SnrBits-1:0]      snr,
    output logic                             invalid,
    input  logic                             cfg_we,
    input  logic                             cfg_index,
    input  logic [36:0]                      cfg_data
);
    import wse_pkg::*;

    logic     in_ready, job_valid, job_ready, res_valid;
    wse_job_t job;

    wse_front u_front (
        .clk, .rst_n,
        .cfg_we(cfg_we && cfg_index == REG_LENGTH), .cfg_len(cfg_data),
        .cfg_inf_we(cfg_we && cfg_index == REG_INFINITE), .cfg_inf(cfg_data[0]),
        .in_valid(push), .in_op(op), .in_sample(sample),
        .in_ready, .job_valid, .job, .job_ready
    );

    wse_back u_back (
        .clk, .rst_n, .job_valid, .job, .job_ready,
        .res_valid, .res_snr(snr), .res_invalid(invalid), .res_pop(pop)
    );

    assign full = !in_ready;
    assign empty = !res_valid;
endmodule

// ===== src/wse_checker.sv =====
// Port-level checker for the windowed SNR estimator and its binding.
`include "assert_macros.svh"
module wse_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [47:0] snr,
    input logic        invalid
);
    `ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(snr))
    `ASSERT_IMP(a_known, clk, rst_n, !empty, !$isunknown({snr, invalid}))
    `ASSERT_NEXT(a_inv_hold, clk, rst_n, !empty && !pop, $stable(invalid))
endmodule

bind windowed_snr_estimator wse_checker u_chk (.*);

// ===== bench/testbench.sv =====
// Self-checking bench for the windowed SNR estimator: a predictor plus a scoreboard.
`timescale 1ns / 100ps

module testbench;
    import wse_pkg::*;

    localparam int STALL_LIMIT = 3000000;
    localparam bit [36:0] LEN_ONE = 37'd65536;
    localparam bit [36:0] LEN_TOP = 37'd68719476736;

    typedef struct {
        bit [47:0] snr;
        bit        invalid;
    } snr_result_t;

    // Window statistics predictor and the queue of SNR results it expects.
    class snr_scoreboard;
        bit [36:0]   length_reg;
        bit          infinite_reg;
        bit [20:0]   count;
        longint      sum1;
        bit [63:0]   sum2;
        bit [63:0]   end_pos;
        bit [63:0]   start_pos;
        bit [20:0]   size;
        bit          overflow;
        snr_result_t due[$];
        int          mismatches;

        function bit [63:0] eff_length();
            bit [63:0] l;
            l = length_reg;
            if (l < 64'd65536) l = 64'd65536;
            if (l > 64'(LEN_TOP)) l = 64'(LEN_TOP);
            return l;
        endfunction

        function bit [63:0] ceil_pos(bit [63:0] pos);
            bit [63:0] c;
            c = (pos >> 16) + ((pos[15:0] != 0) ? 64'd1 : 64'd0);
            return c & 64'hFFFF_FFFF_FFFF;
        endfunction

        function void clear_sums();
            count = 0;
            sum1 = 0;
            sum2 = 0;
            overflow = 0;
        endfunction

        function void restart();
            bit [63:0] c;
            clear_sums();
            end_pos = eff_length();
            start_pos = 0;
            c = ceil_pos(end_pos);
            size = (c > 64'h1F_FFFF) ? 21'h1F_FFFF : c[20:0];
        endfunction

        function void reset_all();
            length_reg = 37'd67108864;
            infinite_reg = 0;
            mismatches = 0;
            due.delete();
            restart();
        endfunction

        function void write_reg(logic idx, bit [36:0] data);
            if (idx == REG_LENGTH) begin
                length_reg = data;
                restart();
            end else begin
                infinite_reg = data[0];
            end
        endfunction

        // Close the window: compute SNR, queue it, advance the schedule.
        function void close_window();
            bit [255:0]  mag, s1sq, ns2, num, den, q;
            bit [63:0]   c;
            snr_result_t r;
            mag = (sum1 < 0) ? 256'(-sum1) : 256'(sum1);
            s1sq = mag * mag;
            ns2 = 256'(count) * 256'(sum2);
            r.snr = '1;
            r.invalid = overflow;
            if (count < 2 || ns2 <= s1sq) begin
                r.invalid = 1;
            end else begin
                den = 256'(count - 1) * (ns2 - s1sq);
                num = (256'(count) * s1sq) << 16;
                q = num / den;
                if (q < (256'd1 << 48)) r.snr = q[47:0];
            end
            due.push_back(r);
            clear_sums();
            start_pos = ceil_pos(end_pos);
            end_pos = end_pos + eff_length();
            c = (ceil_pos(end_pos) - start_pos) & 64'hFFFF_FFFF_FFFF;
            if (c == 0) c = 1;
            size = (c > 64'h1F_FFFF) ? 21'h1F_FFFF : c[20:0];
        endfunction

        function void note_input(logic o, logic [15:0] s);
            longint    x;
            bit [63:0] sq;
            if (o == OP_FLUSH) begin
                if (count != 0) close_window();
                return;
            end
            if (count >= 21'h10_0000) begin
                overflow = 1;
            end else begin
                x = longint'($signed(s));
                sq = 64'(x * x);
                sum1 += x;
                if (sum2 > ~sq) sum2 = '1;
                else sum2 += sq;
                count++;
            end
            if (!infinite_reg && count >= size) close_window();
        endfunction

        function void check_result(bit [47:0] s, bit inv);
            snr_result_t e;
            if (due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result snr=%h invalid=%b", s, inv);
                return;
            end
            e = due.pop_front();
            if (e.snr !== s || e.invalid !== inv) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected snr=%h invalid=%b, got snr=%h invalid=%b",
                             e.snr, e.invalid, s, inv);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        op;
    logic [15:0] sample;
    logic        empty;
    logic        pop;
    logic [47:0] snr;
    logic        invalid;
    logic        cfg_we;
    logic        cfg_index;
    logic [36:0] cfg_data;

    snr_scoreboard sb;
    int  burst_left;
    bit  hold_request;
    int  cycles = 0;

    windowed_snr_estimator uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .op(op), .sample(sample),
        .empty(empty), .pop(pop), .snr(snr), .invalid(invalid),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Watchdog: end the run if the block stops making progress.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: pop on a rotating stall pattern; hold off for a long stretch on request.
    initial
    begin : receiver
        bit [7:0]    pattern;
        int          phase;
        int          hold_left;
        logic        seen_empty;
        logic [47:0] seen_snr;
        logic        seen_invalid;
        pattern = 8'hFF;
        phase = 0;
        hold_left = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            seen_empty = empty;
            seen_snr = snr;
            seen_invalid = invalid;
            @(posedge clk);
            // the pop seen here is the one driven at the previous edge
            if (pop && !seen_empty) sb.check_result(seen_snr, seen_invalid);
            if (hold_request) begin
                hold_request = 0;
                hold_left = 400;
            end
            phase++;
            if (phase % 64 == 0)
                pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= pattern[phase % 8];
            end
        end
    end

    // Offer one transaction and hold it until accepted; then maybe open a gap.
    task automatic send(input logic o, input logic [15:0] s);
        logic ready;
        push <= 1'b1;
        op <= o;
        sample <= s;
        do begin
            @(negedge clk);
            ready = !full;
            @(posedge clk);
        end while (!ready);
        sb.note_input(o, s);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            if ($urandom_range(0, 3) != 0) begin
                push <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
        end
    endtask

    // Drop push, wait for every expected result, then let the block idle.
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (sb.due.size() != 0) @(posedge clk);
        repeat (130) @(posedge clk);
    endtask

    // Drop push so that no transaction shares the edge of the register write.
    task automatic write_reg(input logic idx, input logic [36:0] data);
        push <= 1'b0;
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    function automatic logic [15:0] random_sample(int kind);
        case (kind)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 15)) - 16'd8;
            2: return 16'h7FFF;
            3: return 16'h8000;
            4: return 16'd1000 + 16'($urandom_range(0, 3));
            default: return 16'(-1000) + 16'($urandom_range(0, 300));
        endcase
    endfunction

    initial
    begin : main
        bit [36:0] lengths [8];
        int        items;
        int        kind;
        sb = new();
        sb.reset_all();
        burst_left = 0;
        hold_request = 0;
        rst_n = 1'b0;
        push = 1'b0;
        op = OP_ADD;
        sample = '0;
        pop = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_LENGTH;
        cfg_data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty flush, extremes, constant window, lone-sample flush.
        send(OP_FLUSH, 16'h0000);
        write_reg(REG_LENGTH, 37'd262144);
        send(OP_ADD, 16'h7FFF);
        send(OP_ADD, 16'h8000);
        send(OP_ADD, 16'h0000);
        send(OP_ADD, 16'hFFFF);
        repeat (4) send(OP_ADD, 16'h1234);
        send(OP_ADD, 16'h5555);
        send(OP_FLUSH, 16'hFFFF);
        send(OP_ADD, 16'hAAAA);
        send(OP_ADD, 16'h0001);
        send(OP_FLUSH, 16'h0000);
        send(OP_FLUSH, 16'h0000);
        settle();
        // Restart with a partial window in flight: sums clear, nothing emitted.
        send(OP_ADD, 16'h0100);
        settle();
        write_reg(REG_LENGTH, 37'd163840);
        // Infinite mode, then switch it off past the window size.
        write_reg(REG_INFINITE, 37'd1);
        repeat (5) send(OP_ADD, random_sample(0));
        settle();
        write_reg(REG_INFINITE, 37'd0);
        send(OP_ADD, 16'h0042);
        settle();
        // Clamped lengths at both ends.
        write_reg(REG_LENGTH, 37'd0);
        send(OP_ADD, 16'h0007);
        settle();
        write_reg(REG_LENGTH, 37'h1F_FFFF_FFFF);
        send(OP_ADD, 16'h7FFF);
        send(OP_ADD, 16'h8001);
        send(OP_FLUSH, 16'h0000);
        settle();

        // Random phases over a spread of window lengths.
        lengths[0] = LEN_ONE;
        lengths[1] = 37'd98304;
        lengths[2] = 37'd176947;
        lengths[3] = 37'd327803;
        lengths[4] = 37'd802816;
        lengths[5] = 37'd1000;
        lengths[6] = LEN_TOP;
        lengths[7] = 37'($urandom_range(65536, 1500000));
        for (int p = 0; p < 8; p++) begin
            write_reg(REG_LENGTH, lengths[p]);
            write_reg(REG_INFINITE, 37'(p == 3));
            items = (p == 0) ? 120 : 85;
            kind = $urandom_range(0, 5);
            // Flood a one-sample window while the receiver sits idle.
            if (p == 0) hold_request = 1;
            for (int i = 0; i < items; i++) begin
                if (i % 12 == 0) kind = $urandom_range(0, 5);
                if ($urandom_range(0, 99) < ((p >= 3 && p != 5) ? 12 : 4))
                    send(OP_FLUSH, 16'($urandom));
                else
                    send(OP_ADD, random_sample(kind));
            end
            send(OP_FLUSH, 16'h0000);
            settle();
        end

        if (sb.mismatches == 0 && sb.due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+src
src/wse_pkg.sv
src/wse_front.sv
src/wse_back.sv
src/windowed_snr_estimator.sv
src/wse_checker.sv
bench/testbench.sv
